@@ hdl/url_path_decoder_assert.svh @@
// assertion helpers used by the checker file
`ifndef URL_PATH_DECODER_ASSERT_SVH
`define URL_PATH_DECODER_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define UPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("url_path_decoder check failed");

// next-cycle implication, quiet while reset is held
`define UPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("url_path_decoder check failed");

`endif

@@ hdl/upd_pkg.sv @@
package upd_pkg;

  localparam int UPD_MAX_PATH = 1024;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'h7f;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_DECODE  = 2'd1,
    VERDICT_TRAVERS = 2'd2,
    VERDICT_CONTROL = 2'd3
  } verdict_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] b);
    hex_digit_t d;
    d.ok    = 1'b1;
    d.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d.value = 4'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d.value = 4'(b - 8'h41 + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

@@ hdl/url_path_decoder.sv @@
// channel  | ports                                             | direction
// ---------+---------------------------------------------------+----------
// input    | in_valid, in_ready, in_byte, in_byte_present,     | in
//          | in_path_end                                       |
// result   | out_valid, out_ready, out_byte, out_byte_valid,   | out
//          | out_verdict_valid, out_verdict, out_path_empty    |
//
// one transaction in, one transaction out; a new byte is taken every cycle unless a held result is stalled
// the result appears in the cycle after acceptance, set by the single result register
// the decode state and the result register update together on acceptance
// a stalled result still lets the next byte in when out_ready is high that cycle
// rst_n is synchronous, active low; it clears the escape state, flags and count
module url_path_decoder
  import upd_pkg::*;
#(
  parameter int MAX_PATH = UPD_MAX_PATH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_byte_present,
  input  logic       in_path_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_verdict_valid,
  output logic [1:0] out_verdict,
  output logic       out_path_empty
);

  localparam int CNT_W = (MAX_PATH > 2) ? $clog2(MAX_PATH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PATH - 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [3:0]       nib_r, nib_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fail_r, fail_nxt;
  logic             trav_r, trav_nxt;
  logic             ctrl_r, ctrl_nxt;
  logic             dot_r, dot_nxt;

  logic             out_valid_r;
  logic [7:0]       byte_r, byte_nxt;
  logic             bvalid_r, bvalid_nxt;
  logic             vvalid_r, vvalid_nxt;
  verdict_t         verdict_r, verdict_nxt;
  logic             empty_r, empty_nxt;

  hex_digit_t       dig;
  logic             emit;
  logic [7:0]       ch;
  logic             in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign dig      = hex_digit(in_byte);

  always_comb begin
    phase_nxt   = phase_r;
    nib_nxt     = nib_r;
    cnt_nxt     = cnt_r;
    fail_nxt    = fail_r;
    trav_nxt    = trav_r;
    ctrl_nxt    = ctrl_r;
    dot_nxt     = dot_r;
    emit        = 1'b0;
    ch          = in_byte;
    verdict_nxt = VERDICT_OK;
    empty_nxt   = 1'b0;

    if (in_byte_present && !fail_r) begin
      case (phase_r)
        PH_HIGH: begin
          if (!dig.ok) begin
            fail_nxt = 1'b1;
          end else begin
            nib_nxt   = dig.value;
            phase_nxt = PH_LOW;
          end
        end
        PH_LOW: begin
          // %00 is refused like a bad digit
          if (!dig.ok || (nib_r == 4'd0 && dig.value == 4'd0)) begin
            fail_nxt = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
            ch        = {nib_r, dig.value};
          end
        end
        default: begin
          if (cnt_r == CNT_LAST) begin
            fail_nxt = 1'b1;
          end else if (in_byte == CH_PERCENT) begin
            phase_nxt = PH_HIGH;
          end else begin
            emit = 1'b1;
          end
        end
      endcase
    end

    if (emit) begin
      if (ch < CH_SPACE || ch == CH_DEL) begin
        ctrl_nxt = 1'b1;
      end
      if (ch == CH_DOT && dot_r) begin
        trav_nxt = 1'b1;
      end
      dot_nxt = (ch == CH_DOT);
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end

    byte_nxt   = emit ? ch : 8'h00;
    bvalid_nxt = emit;
    vvalid_nxt = in_path_end;

    if (in_path_end) begin
      // an escape left open at the end is a decode error
      if (phase_nxt != PH_IDLE) begin
        fail_nxt = 1'b1;
      end
      if (fail_nxt) begin
        verdict_nxt = VERDICT_DECODE;
      end else if (trav_nxt) begin
        verdict_nxt = VERDICT_TRAVERS;
      end else if (ctrl_nxt) begin
        verdict_nxt = VERDICT_CONTROL;
      end else begin
        verdict_nxt = VERDICT_OK;
      end
      empty_nxt = (verdict_nxt == VERDICT_OK) && (cnt_nxt == '0);
      phase_nxt = PH_IDLE;
      nib_nxt   = 4'd0;
      cnt_nxt   = '0;
      fail_nxt  = 1'b0;
      trav_nxt  = 1'b0;
      ctrl_nxt  = 1'b0;
      dot_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      nib_r       <= 4'd0;
      cnt_r       <= '0;
      fail_r      <= 1'b0;
      trav_r      <= 1'b0;
      ctrl_r      <= 1'b0;
      dot_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        nib_r       <= nib_nxt;
        cnt_r       <= cnt_nxt;
        fail_r      <= fail_nxt;
        trav_r      <= trav_nxt;
        ctrl_r      <= ctrl_nxt;
        dot_r       <= dot_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded on every accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r    <= byte_nxt;
      bvalid_r  <= bvalid_nxt;
      vvalid_r  <= vvalid_nxt;
      verdict_r <= verdict_nxt;
      empty_r   <= empty_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = byte_r;
  assign out_byte_valid    = bvalid_r;
  assign out_verdict_valid = vvalid_r;
  assign out_verdict       = verdict_r;
  assign out_path_empty    = empty_r;

endmodule

@@ hdl/upd_checker.sv @@
`include "url_path_decoder_assert.svh"

module upd_checker
  import upd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_verdict_valid,
  input logic [1:0] out_verdict,
  input logic       out_path_empty
);

  // a stalled result keeps its decoded byte
  `UPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))

  // every accepted transaction shows up as a result in the next cycle
  `UPD_ASSERT_NEXT(a_one_result, in_valid && in_ready, out_valid)

  // verdict fields are quiet outside the end of a path
  `UPD_ASSERT_NOW(a_verdict_quiet, out_valid && !out_verdict_valid,
    out_verdict == VERDICT_OK && !out_path_empty)

  // an empty path is only reported with an ok verdict
  `UPD_ASSERT_NOW(a_empty_ok, out_valid && out_path_empty,
    out_verdict_valid && out_verdict == VERDICT_OK && !out_byte_valid)

  // no decoded byte means a zero byte field
  `UPD_ASSERT_NOW(a_byte_quiet, out_valid && !out_byte_valid, out_byte == 8'h00)

endmodule

bind url_path_decoder upd_checker u_upd_checker (.*);

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import upd_pkg::*;

  localparam int RANDOM_ITEMS   = 550;
  localparam int CALM_ITEMS     = 40;
  localparam int LONG_HOLD      = 64;
  localparam int HOLD_PATH      = 6;
  localparam int TAIL_CYCLES    = 10;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_stage_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } path_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       verdict_valid;
    verdict_t   verdict;
    logic       empty;
  } path_result_t;

  // tracks the decode of the current path and holds the results still owed
  class path_scoreboard;
    path_result_t expected_q[$];
    int           errors;
    esc_stage_t   esc;
    logic [3:0]   hi_digit;
    int unsigned  char_count;
    bit           failed;
    bit           dotdot;
    bit           ctrl;
    bit           last_dot;

    function new();
      errors = 0;
      clear_path();
    endfunction

    function void clear_path();
      esc        = ESC_NONE;
      hi_digit   = 4'd0;
      char_count = 0;
      failed     = 1'b0;
      dotdot     = 1'b0;
      ctrl       = 1'b0;
      last_dot   = 1'b0;
    endfunction

    function int hex_val(logic [7:0] b);
      if (b inside {[8'h30:8'h39]}) return int'(b) - 'h30;
      if (b inside {[8'h41:8'h46]}) return int'(b) - 'h41 + 10;
      if (b inside {[8'h61:8'h66]}) return int'(b) - 'h61 + 10;
      return -1;
    endfunction

    function void note_input(path_item_t it);
      path_result_t r;
      int           d;
      logic [7:0]   ch;
      bit           emit;
      r    = '0;
      ch   = 8'd0;
      emit = 1'b0;
      if (it.present && !failed) begin
        case (esc)
          ESC_HIGH: begin
            d = hex_val(it.data);
            if (d < 0) begin
              failed = 1'b1;
            end else begin
              hi_digit = d[3:0];
              esc = ESC_LOW;
            end
          end
          ESC_LOW: begin
            d = hex_val(it.data);
            if (d < 0 || (hi_digit == 4'd0 && d == 0)) begin
              failed = 1'b1;
            end else begin
              esc  = ESC_NONE;
              ch   = {hi_digit, d[3:0]};
              emit = 1'b1;
            end
          end
          default: begin
            // no room left for another decoded character
            if (char_count + 1 >= UPD_MAX_PATH) begin
              failed = 1'b1;
            end else if (it.data == CH_PERCENT) begin
              esc = ESC_HIGH;
            end else begin
              ch   = it.data;
              emit = 1'b1;
            end
          end
        endcase
      end
      if (emit) begin
        if (ch < CH_SPACE || ch == CH_DEL) ctrl = 1'b1;
        if (ch == CH_DOT) begin
          if (last_dot) dotdot = 1'b1;
          last_dot = 1'b1;
        end else begin
          last_dot = 1'b0;
        end
        char_count++;
        r.data       = ch;
        r.data_valid = 1'b1;
      end
      if (it.last) begin
        if (esc != ESC_NONE) failed = 1'b1;
        r.verdict_valid = 1'b1;
        if (failed) r.verdict = VERDICT_DECODE;
        else if (dotdot) r.verdict = VERDICT_TRAVERS;
        else if (ctrl) r.verdict = VERDICT_CONTROL;
        else r.verdict = VERDICT_OK;
        r.empty = (r.verdict == VERDICT_OK && char_count == 0);
        clear_path();
      end
      expected_q.push_back(r);
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(path_result_t got);
      path_result_t want;
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing outstanding: byte 0x%0h verdict %0d",
               got.data, got.verdict);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      field_check("out_byte", want.data, got.data);
      field_check("out_byte_valid", 8'(want.data_valid), 8'(got.data_valid));
      field_check("out_verdict_valid", 8'(want.verdict_valid), 8'(got.verdict_valid));
      field_check("out_verdict", 8'(want.verdict), 8'(got.verdict));
      field_check("out_path_empty", 8'(want.empty), 8'(got.empty));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'd0;
  logic       in_byte_present = 1'b0;
  logic       in_path_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_verdict_valid;
  logic [1:0] out_verdict;
  logic       out_path_empty;

  path_scoreboard board = new();
  path_item_t     plan[$];
  int             items_sent = 0;
  bit             calm = 1'b0;
  bit             tx_bursty = 1'b0;
  bit             rx_bursty = 1'b0;
  bit             hold_request = 1'b0;

  url_path_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_byte_present   (in_byte_present),
    .in_path_end       (in_path_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_verdict_valid (out_verdict_valid),
    .out_verdict       (out_verdict),
    .out_path_empty    (out_path_empty)
  );

  always #10 clk = ~clk;

  // hex digit with the letter case picked at random
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] bad_digit();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (board.hex_val(b) >= 0);
    return b;
  endfunction

  function automatic logic [7:0] random_plain();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: return CH_PLUS;
      1: return CH_DOT;
      2: return ($urandom_range(0, 4) == 0) ? CH_DEL : 8'($urandom_range(0, 31));
      3: return 8'($urandom_range(128, 255));
      4: return CH_SPACE;
      default: begin
        b = 8'($urandom_range(33, 126));
        if (b == CH_PERCENT) b = CH_SLASH;
        return b;
      end
    endcase
  endfunction

  task automatic push_item(logic [7:0] b, logic present, logic last);
    path_item_t it;
    it.data    = b;
    it.present = present;
    it.last    = last;
    plan.push_back(it);
  endtask

  task automatic add_escape(logic [7:0] v, logic last);
    push_item(CH_PERCENT, 1'b1, 1'b0);
    push_item(hex_char(v[7:4]), 1'b1, 1'b0);
    push_item(hex_char(v[3:0]), 1'b1, last);
  endtask

  task automatic add_dot();
    if ($urandom_range(0, 1) == 0) push_item(CH_DOT, 1'b1, 1'b0);
    else add_escape(CH_DOT, 1'b0);
  endtask

  task automatic add_random_path();
    int kind;
    int len;
    int fault_at;
    kind     = $urandom_range(0, 9);
    len      = (kind == 8) ? 0 : $urandom_range(1, 12);
    fault_at = (kind == 6) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (kind == 7) begin
        // noise: any byte, sometimes not present
        push_item(8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0, 1'b0);
        continue;
      end
      if (i == fault_at) begin
        case ($urandom_range(0, 2))
          0: begin
            push_item(CH_PERCENT, 1'b1, 1'b0);
            push_item(bad_digit(), 1'b1, 1'b0);
          end
          1: begin
            push_item(CH_PERCENT, 1'b1, 1'b0);
            push_item(hex_char(4'($urandom_range(0, 15))), 1'b1, 1'b0);
            push_item(bad_digit(), 1'b1, 1'b0);
          end
          default: add_escape(8'h00, 1'b0);
        endcase
      end
      if (kind == 9) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: add_dot();
          5, 6: push_item(CH_SLASH, 1'b1, 1'b0);
          default: push_item(random_plain(), 1'b1, 1'b0);
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: push_item(random_plain(), 1'b1, 1'b0);
          5, 6, 7: add_escape(8'($urandom_range(1, 255)), 1'b0);
          8: begin
            add_dot();
            add_dot();
          end
          default: push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        endcase
      end
    end
    case ($urandom_range(0, 7))
      0, 1, 2, 3: push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      4, 5, 6: push_item(random_plain(), 1'b1, 1'b1);
      default: begin
        // escape cut short by the end of the path
        case ($urandom_range(0, 2))
          0: push_item(CH_PERCENT, 1'b1, 1'b1);
          1: begin
            push_item(CH_PERCENT, 1'b1, 1'b0);
            push_item(hex_char(4'($urandom_range(0, 15))), 1'b1, 1'b1);
          end
          default: begin
            push_item(CH_PERCENT, 1'b1, 1'b0);
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
          end
        endcase
      end
    endcase
  endtask

  // valid stays high from one transaction to the next unless a gap is taken
  task automatic send_item(path_item_t it);
    if (!calm && tx_bursty && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte         <= it.data;
    in_byte_present <= it.present;
    in_path_end     <= it.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(it);
  endtask

  task automatic drive_plan();
    path_item_t it;
    while (plan.size() != 0) begin
      it = plan.pop_front();
      send_item(it);
      if (it.present || it.last) items_sent++;
    end
  endtask

  // result side: check each transaction, then pick the next ready level
  initial begin
    path_result_t got;
    int           stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.data          = out_byte;
        got.data_valid    = out_byte_valid;
        got.verdict_valid = out_verdict_valid;
        got.verdict       = verdict_t'(out_verdict);
        got.empty         = out_path_empty;
        board.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end else if (stall_left == 0 && !calm && rx_bursty && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int path_no;
    path_no = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    tx_bursty = 1'b1;
    rx_bursty = 1'b1;
    // empty path, then an idle transaction
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b0);
    // escaped letter plus a plus sign
    add_escape(8'h41, 1'b0);
    push_item(CH_PLUS, 1'b1, 1'b1);
    // raw dot then escaped dot
    push_item(CH_DOT, 1'b1, 1'b0);
    add_escape(CH_DOT, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    // raw zero byte, top byte value on the end transaction
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b1, 1'b1);
    add_escape(8'h00, 1'b1);
    // bad high digit, rest of the path swallowed
    push_item(CH_PERCENT, 1'b1, 1'b0);
    push_item(8'h47, 1'b1, 1'b0);
    push_item(8'h61, 1'b1, 1'b1);
    // bad low digit
    push_item(CH_PERCENT, 1'b1, 1'b0);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h7a, 1'b1, 1'b1);
    // escape cut short
    push_item(CH_PERCENT, 1'b1, 1'b0);
    push_item(8'h37, 1'b1, 1'b1);
    add_escape(CH_DEL, 1'b1);
    drive_plan();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      path_no++;
      calm      = (items_sent >= RANDOM_ITEMS - CALM_ITEMS);
      tx_bursty = !calm && ($urandom_range(0, 3) != 0);
      rx_bursty = !calm && ($urandom_range(0, 3) != 0);
      // receiver backs off for a long stretch while this path keeps coming
      if (path_no == HOLD_PATH) hold_request = 1'b1;
      add_random_path();
      drive_plan();
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
